// ----- src/hsvrgb_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
package hsvrgb_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SATURATION  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VALUE_LEVEL = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0] SATURATION_RST  = 8'd255;
  localparam logic [7:0] VALUE_LEVEL_RST = 8'd255;

  // Hue sectors of 60 degrees each.
  localparam logic [2:0] SEC_RED_YELLOW     = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN   = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN     = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE      = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA   = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED    = 3'd5;

  // Weight of each byte of the hue magnitude, 256^i mod 360, for up to four bytes.
  localparam int unsigned HUE_MAX_BYTES = 4;
  localparam logic [HUE_MAX_BYTES-1:0][8:0] HUE_WEIGHT = {9'd136, 9'd16, 9'd256, 9'd1};

  // Width of the weighted byte sum; it stays below 4 * 255 * 359.
  localparam int unsigned FOLD_SUM_BITS = 19;

  // floor(2^27 / 360): the quotient estimate is low by at most one.
  localparam logic [18:0] RECIP_360       = 19'd372827;
  localparam int unsigned RECIP_360_SHIFT = 27;

  // ceil(2^36 / 15300): exact floor division for numerators below 2^22.
  localparam logic [22:0] RECIP_15300       = 23'd4491470;
  localparam int unsigned RECIP_15300_SHIFT = 36;

  localparam logic [13:0] FULL_SCALE = 14'd15300;

  // Folded hue handed from the hue folding stages to the colour stages.
  typedef struct packed {
    logic       valid;
    logic [2:0] sector;
    logic [5:0] frac;
  } hsvrgb_hue_t;

endpackage

// ----- src/hsvrgb_hue_if.sv -----
// Input channel carrying one signed hue per beat.
interface hsvrgb_hue_if #(
  parameter int unsigned HUE_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [HUE_BITS-1:0] hue;

  modport source (output valid, output hue, input ready);
  modport sink (input valid, input hue, output ready);
endinterface

// ----- src/hsvrgb_rgb_if.sv -----
// Result channel carrying one RGB colour per beat.
interface hsvrgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/hsvrgb_cfg_if.sv -----
// Configuration write channel: register index and write data per beat.
interface hsvrgb_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [hsvrgb_pkg::CFG_IDX_BITS-1:0]   index;
  logic [7:0]                            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/hsvrgb_hue_fold.sv -----
// Hue folding pipeline: magnitude, modulo 360, then sector and fraction.
module hsvrgb_hue_fold #(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic signed [HUE_BITS-1:0] hue,
  output hsvrgb_pkg::hsvrgb_hue_t    fold
);

  localparam int unsigned NBYTES = (HUE_BITS + 7) / 8;
  localparam int unsigned SB     = hsvrgb_pkg::FOLD_SUM_BITS;
  localparam int unsigned QSH    = hsvrgb_pkg::RECIP_360_SHIFT;

  logic [4:0]          vld_r;
  logic [HUE_BITS-1:0] mag_r;
  logic [SB-1:0]       sum_r;
  logic [SB-1:0]       sum2_r;
  logic [9:0]          quo_r;
  logic [8:0]          hdeg_r;
  logic [2:0]          sector_r;
  logic [5:0]          frac_r;

  logic [HUE_BITS-1:0] mag_nxt;
  logic [NBYTES*8-1:0] mag_pad;
  logic [SB-1:0]       sum_nxt;
  logic [2*SB-1:0]     quo_prod;
  logic [SB-1:0]       rem_full;
  logic [9:0]          rem;
  logic [8:0]          hdeg_nxt;
  logic [2:0]          sector_nxt;
  logic [8:0]          base;
  logic [8:0]          frac_full;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Stage one: magnitude of the two's complement hue (the most negative value fits unsigned).
  assign mag_nxt = hue[HUE_BITS-1] ? (~hue + 1'b1) : hue;

  // Stage two: reduce by byte, each byte weighted by its power of 256 modulo 360.
  assign mag_pad = (NBYTES*8)'(mag_r);

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NBYTES; i++) begin
      sum_nxt = sum_nxt + SB'(mag_pad[8*i +: 8]) * SB'(hsvrgb_pkg::HUE_WEIGHT[i]);
    end
  end

  // Stage three: quotient estimate by a reciprocal multiply.
  assign quo_prod = (2*SB)'(sum_r) * (2*SB)'(hsvrgb_pkg::RECIP_360);

  // Stage four: remainder, with one correction step since the estimate may be low by one.
  assign rem_full = sum2_r - SB'(quo_r) * SB'(360);
  assign rem      = rem_full[9:0];
  assign hdeg_nxt = (rem >= 10'd360) ? 9'(rem - 10'd360) : rem[8:0];

  // Stage five: sector and fraction within the sector.
  always_comb begin
    if (hdeg_r >= 9'd300) begin
      sector_nxt = hsvrgb_pkg::SEC_MAGENTA_RED;
    end else if (hdeg_r >= 9'd240) begin
      sector_nxt = hsvrgb_pkg::SEC_BLUE_MAGENTA;
    end else if (hdeg_r >= 9'd180) begin
      sector_nxt = hsvrgb_pkg::SEC_CYAN_BLUE;
    end else if (hdeg_r >= 9'd120) begin
      sector_nxt = hsvrgb_pkg::SEC_GREEN_CYAN;
    end else if (hdeg_r >= 9'd60) begin
      sector_nxt = hsvrgb_pkg::SEC_YELLOW_GREEN;
    end else begin
      sector_nxt = hsvrgb_pkg::SEC_RED_YELLOW;
    end
  end

  always_comb begin
    case (sector_nxt)
      hsvrgb_pkg::SEC_YELLOW_GREEN: base = 9'd60;
      hsvrgb_pkg::SEC_GREEN_CYAN:   base = 9'd120;
      hsvrgb_pkg::SEC_CYAN_BLUE:    base = 9'd180;
      hsvrgb_pkg::SEC_BLUE_MAGENTA: base = 9'd240;
      hsvrgb_pkg::SEC_MAGENTA_RED:  base = 9'd300;
      default:                      base = 9'd0;
    endcase
  end

  assign frac_full = hdeg_r - base;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r    <= mag_nxt;
      sum_r    <= sum_nxt;
      sum2_r   <= sum_r;
      quo_r    <= quo_prod[QSH+9:QSH];
      hdeg_r   <= hdeg_nxt;
      sector_r <= sector_nxt;
      frac_r   <= frac_full[5:0];
    end
  end

  assign fold.valid  = vld_r[4];
  assign fold.sector = sector_r;
  assign fold.frac   = frac_r;

endmodule

// ----- src/hsv_to_rgb_pixel.sv -----
// Top level of the HSV to RGB pixel converter.
//
//   Channel   Direction  Beat contents
//   in_if     sink       hue, HUE_BITS bits, two's complement
//   out_if    source     red, green, blue, 8 bits each
//   cfg_if    sink       index 0 saturation, index 1 value level, 8-bit data
//
// One hue is taken every cycle unless the output stalls. Each hue passes through
// nine register stages: five for folding the hue and four for the products,
// the reciprocal divisions and the sector select.
// Reset sets saturation and value level to 255 and empties the pipeline.
// When a result waits at the output, the whole pipeline holds and in_if.ready falls.
// Configuration writes are always ready and take effect at once.
module hsv_to_rgb_pixel #(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  hsvrgb_hue_if.sink             in_if,
  hsvrgb_rgb_if.source           out_if,
  hsvrgb_cfg_if.sink             cfg_if
);

  localparam int unsigned DSH = hsvrgb_pkg::RECIP_15300_SHIFT;

  logic [7:0]  sat_r;
  logic [7:0]  val_r;
  logic        adv;
  hsvrgb_pkg::hsvrgb_hue_t fold;

  logic [2:0]  vld_r;
  logic [2:0]  sec6_r;
  logic [2:0]  sec7_r;
  logic [2:0]  sec8_r;
  logic [13:0] sf_r;
  logic [13:0] sg_r;
  logic [15:0] xn_r;
  logic [21:0] yn_r;
  logic [21:0] zn_r;
  logic [7:0]  x7_r;
  logic [7:0]  x8_r;
  logic [7:0]  y_r;
  logic [7:0]  z_r;
  logic        out_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;

  logic [16:0] x_sum;
  logic [44:0] y_prod;
  logic [44:0] z_prod;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= hsvrgb_pkg::SATURATION_RST;
      val_r <= hsvrgb_pkg::VALUE_LEVEL_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == hsvrgb_pkg::CFG_SATURATION) begin
        sat_r <= cfg_if.data;
      end
      if (cfg_if.index == hsvrgb_pkg::CFG_VALUE_LEVEL) begin
        val_r <= cfg_if.data;
      end
    end
  end

  // The pipeline moves whenever the output register is empty or being emptied.
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  hsvrgb_hue_fold #(
    .HUE_BITS (HUE_BITS)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_if.valid),
    .hue      (in_if.hue),
    .fold     (fold)
  );

  // Valid bits of the colour stages and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[1:0], fold.valid};
      out_valid_r <= vld_r[2];
    end
  end

  // Stage seven helper: floor(n / 255) for n below 65280.
  assign x_sum = 17'(xn_r) + 17'(xn_r[15:8]) + 17'd1;

  // Stage eight: exact division by 15300 through a rounded-up reciprocal.
  assign y_prod = 45'(yn_r) * 45'(hsvrgb_pkg::RECIP_15300);
  assign z_prod = 45'(zn_r) * 45'(hsvrgb_pkg::RECIP_15300);

  // Stage nine: pick the channels for the sector.
  always_comb begin
    case (sec8_r)
      hsvrgb_pkg::SEC_RED_YELLOW: begin
        red_nxt = val_r; green_nxt = z_r;   blue_nxt = x8_r;
      end
      hsvrgb_pkg::SEC_YELLOW_GREEN: begin
        red_nxt = y_r;   green_nxt = val_r; blue_nxt = x8_r;
      end
      hsvrgb_pkg::SEC_GREEN_CYAN: begin
        red_nxt = x8_r;  green_nxt = val_r; blue_nxt = z_r;
      end
      hsvrgb_pkg::SEC_CYAN_BLUE: begin
        red_nxt = x8_r;  green_nxt = y_r;   blue_nxt = val_r;
      end
      hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
        red_nxt = z_r;   green_nxt = x8_r;  blue_nxt = val_r;
      end
      default: begin
        red_nxt = val_r; green_nxt = x8_r;  blue_nxt = y_r;
      end
    endcase
  end

  // Payload registers of the colour stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage six: saturation products and the numerator of X.
      sec6_r  <= fold.sector;
      sf_r    <= 14'(sat_r) * 14'(fold.frac);
      sg_r    <= 14'(sat_r) * 14'(6'd60 - fold.frac);
      xn_r    <= 16'(val_r) * 16'(8'd255 - sat_r);
      // Stage seven: value products and X.
      sec7_r  <= sec6_r;
      yn_r    <= 22'(val_r) * 22'(hsvrgb_pkg::FULL_SCALE - sf_r);
      zn_r    <= 22'(val_r) * 22'(hsvrgb_pkg::FULL_SCALE - sg_r);
      x7_r    <= x_sum[15:8];
      // Stage eight: Y and Z.
      sec8_r  <= sec7_r;
      x8_r    <= x7_r;
      y_r     <= y_prod[DSH+7:DSH];
      z_r     <= z_prod[DSH+7:DSH];
      // Output register.
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.red   = red_r;
  assign out_if.green = green_r;
  assign out_if.blue  = blue_r;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGB pixel converter, with its own colour predictor.
module testbench;

  localparam int unsigned HUE_W = 16;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 5;
  localparam int PIPE_LATENCY = 9;
  localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 4;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS = 110;
  localparam int STEADY_BEATS = 280;

  // Register indexes that the block does not implement.
  localparam logic [hsvrgb_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_LOW = 8'd2;
  localparam logic [hsvrgb_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_TOP = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady = 1'b0;

  // Predictor state: a copy of the two registers and the colours still to come.
  logic [7:0] cur_sat = hsvrgb_pkg::SATURATION_RST;
  logic [7:0] cur_val = hsvrgb_pkg::VALUE_LEVEL_RST;
  colour_t    pending_colours [$];
  colour_t    want;
  int         errors = 0;
  int         quiet_cycles = 0;

  hsvrgb_hue_if #(.HUE_BITS(HUE_W)) hue_ch ();
  hsvrgb_rgb_if rgb_ch ();
  hsvrgb_cfg_if cfg_ch ();

  hsv_to_rgb_pixel #(.HUE_BITS(HUE_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (hue_ch),
    .out_if (rgb_ch),
    .cfg_if (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Expected colour for one hue beat, using exact integer arithmetic throughout.
  function automatic colour_t hsv_colour(input logic [HUE_W-1:0] raw, input logic [7:0] sat,
                                         input logic [7:0] val);
    logic [HUE_W:0] magnitude;
    logic [2:0]     sector;
    int unsigned    degrees, frac, s, v, x, y, z, r, g, b;
    colour_t        c;
    // A negative hue is folded by its magnitude; the most negative one needs the extra bit.
    magnitude = raw[HUE_W-1] ? ({1'b1, {HUE_W{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
    degrees = 32'(magnitude);
    degrees = degrees % 360;
    sector = 3'(degrees / 60);
    frac = degrees % 60;
    s = 32'(sat);
    v = 32'(val);
    x = (v * (255 - s)) / 255;
    y = (v * (15300 - s * frac)) / 15300;
    z = (v * (15300 - s * (60 - frac))) / 15300;
    case (sector)
      hsvrgb_pkg::SEC_RED_YELLOW: begin
        r = v; g = z; b = x;
      end
      hsvrgb_pkg::SEC_YELLOW_GREEN: begin
        r = y; g = v; b = x;
      end
      hsvrgb_pkg::SEC_GREEN_CYAN: begin
        r = x; g = v; b = z;
      end
      hsvrgb_pkg::SEC_CYAN_BLUE: begin
        r = x; g = y; b = v;
      end
      hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
        r = z; g = x; b = v;
      end
      default: begin
        r = v; g = x; b = y;
      end
    endcase
    c.red   = (r > 255) ? 8'd255 : 8'(r);
    c.green = (g > 255) ? 8'd255 : 8'(g);
    c.blue  = (b > 255) ? 8'd255 : 8'(b);
    return c;
  endfunction

  // Random hue, weighted towards folding and sector boundaries and the extremes.
  function automatic logic [HUE_W-1:0] random_hue();
    int deg;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: deg = int'($urandom);
      4, 5:       deg = int'($urandom_range(0, 1440)) - 720;
      6, 7:       deg = int'($urandom_range(0, 546)) * 60 + int'($urandom_range(0, 2)) - 1;
      8:          deg = int'($urandom_range(0, 91)) * 360 + int'($urandom_range(0, 2)) - 1;
      default:    deg = 32767 + int'($urandom_range(0, 1));
    endcase
    if ($urandom_range(0, 1) == 1) begin
      deg = -deg;
    end
    return deg[HUE_W-1:0];
  endfunction

  task automatic compare_channel(input string name, input logic [7:0] want_level,
                                 input logic [7:0] got_level);
    if (got_level !== want_level) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_level, got_level);
      errors++;
    end
  endtask

  // Monitor: predicts on each hue beat, checks each colour beat, follows register writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_sat = hsvrgb_pkg::SATURATION_RST;
      cur_val = hsvrgb_pkg::VALUE_LEVEL_RST;
      quiet_cycles = 0;
    end else begin
      if (hue_ch.valid && hue_ch.ready) begin
        pending_colours.push_back(hsv_colour(hue_ch.hue, cur_sat, cur_val));
      end
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (pending_colours.size() == 0) begin
          $display("%0t: colour expected none, got %h", $time,
                   {rgb_ch.red, rgb_ch.green, rgb_ch.blue});
          errors++;
        end else begin
          want = pending_colours.pop_front();
          compare_channel("red", want.red, rgb_ch.red);
          compare_channel("green", want.green, rgb_ch.green);
          compare_channel("blue", want.blue, rgb_ch.blue);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          hsvrgb_pkg::CFG_SATURATION:  cur_sat = cfg_ch.data;
          hsvrgb_pkg::CFG_VALUE_LEVEL: cur_val = cfg_ch.data;
          default: ;
        endcase
      end
      if ((hue_ch.valid && hue_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: ends the run when no beat has moved on any channel for too long.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no beat on any channel for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stalls in random bursts, except in the final part of the run.
  initial begin
    rgb_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 9) == 0) begin
        rgb_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        rgb_ch.ready <= 1'b1;
      end
    end
  end

  // Sends one hue beat, sometimes after a random gap; valid stays high afterwards.
  task automatic send_hue(input logic [HUE_W-1:0] raw);
    @(negedge clk);
    if (!steady && $urandom_range(0, 5) == 0) begin
      hue_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    hue_ch.valid <= 1'b1;
    hue_ch.hue   <= raw;
    do @(posedge clk); while (!hue_ch.ready);
  endtask

  // Holds the sender back until every expected colour has come out.
  task automatic wait_until_drained();
    @(negedge clk);
    hue_ch.valid <= 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [hsvrgb_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [7:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers are only written once the pipeline is empty.
  task automatic set_colour_levels(input logic [7:0] sat, input logic [7:0] val);
    wait_until_drained();
    write_register(hsvrgb_pkg::CFG_SATURATION, sat);
    write_register(hsvrgb_pkg::CFG_VALUE_LEVEL, val);
  endtask

  // Sector and folding boundaries, zero and the extremes of the hue, at reset levels.
  task automatic test_boundary_hues();
    logic signed [HUE_W-1:0] probes [24];
    probes = '{16'sd0, 16'sd1, 16'sd59, 16'sd60, 16'sd61, 16'sd119, 16'sd120, 16'sd180,
               16'sd240, 16'sd300, 16'sd359, 16'sd360, 16'sd361, 16'sd719, -16'sd1,
               -16'sd59, -16'sd60, -16'sd61, -16'sd359, -16'sd360, 16'sd32767,
               -16'sd32767, 16'sh8000, -16'sd32760};
    foreach (probes[i]) begin
      send_hue(probes[i]);
    end
  endtask

  // Extreme and near-extreme settings: a hue per sector, a negative hue, a sector boundary.
  task automatic test_register_extremes();
    logic [7:0] sats [7];
    logic [7:0] vals [7];
    sats = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd254, 8'd128};
    vals = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd254, 8'd1, 8'd128};
    foreach (sats[i]) begin
      set_colour_levels(sats[i], vals[i]);
      for (int sec = 0; sec < 6; sec++) begin
        send_hue(HUE_W'(sec * 60 + int'($urandom_range(0, 59))));
      end
      send_hue(HUE_W'(-int'($urandom_range(1, 32768))));
      send_hue(HUE_W'(int'($urandom_range(0, 5)) * 60));
    end
  endtask

  // Writes to indexes above the last register must leave both levels unchanged.
  task automatic test_unused_registers();
    set_colour_levels(8'd200, 8'd100);
    write_register(CFG_UNUSED_LOW, 8'd0);
    write_register(CFG_UNUSED_TOP, 8'd255);
    repeat (10) send_hue(random_hue());
  endtask

  // Random phases, each with its own levels and a pause half way for the pipeline to empty.
  task automatic test_random_settings();
    logic [7:0] sat, val;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       sat = 8'd0;
        1:       sat = 8'd255;
        default: sat = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       val = 8'd0;
        1:       val = 8'd255;
        default: val = 8'($urandom);
      endcase
      set_colour_levels(sat, val);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2) begin
          wait_until_drained();
        end
        send_hue(random_hue());
      end
    end
  endtask

  // Full rate on both sides: one hue and one colour every cycle.
  task automatic test_back_to_back();
    set_colour_levels(8'($urandom), 8'($urandom));
    steady = 1'b1;
    repeat (STEADY_BEATS) send_hue(random_hue());
  endtask

  initial begin
    rst_n = 1'b0;
    hue_ch.valid = 1'b0;
    hue_ch.hue = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_boundary_hues();
    test_register_extremes();
    test_unused_registers();
    test_random_settings();
    test_back_to_back();

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && pending_colours.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
